[rtl/core/cidf_pkg.sv]
// ----------------------------------------------------------------------------
// cidf_pkg
// Shared constants, codes and control structs of the CAN identifier
// pass/block filter bank.
// ----------------------------------------------------------------------------
package cidf_pkg;

   // default build values
   localparam int NUM_SLOTS_DEF = 7;
   localparam int ID_BITS_DEF   = 32;

   // request limits
   localparam int MAX_LEN       = 4;
   localparam int MAX_RESULTS   = 7;
   localparam int CNT_W         = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

   // field widths
   localparam int CMD_W    = 2;
   localparam int SLOT_W   = 4;
   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int LEN_W    = 4;
   localparam int STATUS_W = 3;
   localparam int MSLOT_W  = 3;
   localparam int CHAN_W   = 8;

   // commands
   localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // filter kinds
   localparam logic [KIND_W-1:0] KIND_PASS  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BLOCK = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FLOW  = 2'd2;

   // result kinds
   localparam logic RES_STATUS  = 1'b0;
   localparam logic RES_FORWARD = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_WRONG_TYPE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MASK_LONG  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PAT_LONG   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LIMIT      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_IN_USE     = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NO_FILTER  = 3'd6;

   // controller to datapath
   typedef struct packed {
      logic capture;     // load the request word
      logic scan_clear;  // restart the slot scan
      logic scan_adv;    // step to the next slot
      logic take_hit;    // hold the current slot as pending result
      logic emit_pend;   // move the pending result to the output register
      logic emit_last;   // mark the emitted result as final
      logic exec_stat;   // run add or remove and answer with a status
   } cidf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;    // output register can take a word this cycle
      logic hit;         // current slot lets the frame through
      logic last_idx;    // scan sits on the final slot
      logic cnt_full;    // one more hit reaches the result limit
      logic pend_valid;  // a pending forward result is held
   } cidf_stat_type;

endpackage

[rtl/core/cidf_req_if.sv]
// ----------------------------------------------------------------------------
// cidf_req_if
// Request channel: valid/ready handshake with one command word.
// ----------------------------------------------------------------------------
interface cidf_req_if;
   logic                          valid;
   logic                          ready;
   logic [cidf_pkg::CMD_W-1:0]    cmd;
   logic [cidf_pkg::SLOT_W-1:0]   slot;
   logic [cidf_pkg::KIND_W-1:0]   filter_kind;
   logic [cidf_pkg::VALUE_W-1:0]  mask_value;
   logic [cidf_pkg::LEN_W-1:0]    mask_length;
   logic [cidf_pkg::VALUE_W-1:0]  pattern_value;
   logic [cidf_pkg::LEN_W-1:0]    pattern_length;
   logic [cidf_pkg::VALUE_W-1:0]  frame_id;

   modport source (
      output valid, cmd, slot, filter_kind, mask_value, mask_length,
             pattern_value, pattern_length, frame_id,
      input  ready
   );

   modport sink (
      input  valid, cmd, slot, filter_kind, mask_value, mask_length,
             pattern_value, pattern_length, frame_id,
      output ready
   );
endinterface

[rtl/core/cidf_rsp_if.sv]
// ----------------------------------------------------------------------------
// cidf_rsp_if
// Response channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface cidf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           result_kind;
   logic [cidf_pkg::STATUS_W-1:0]  status;
   logic [cidf_pkg::MSLOT_W-1:0]   matched_slot;
   logic [cidf_pkg::VALUE_W-1:0]   forwarded_id;
   logic [cidf_pkg::CHAN_W-1:0]    channel;
   logic                           last;

   modport source (
      output valid, result_kind, status, matched_slot, forwarded_id, channel, last,
      input  ready
   );

   modport sink (
      input  valid, result_kind, status, matched_slot, forwarded_id, channel, last,
      output ready
   );
endinterface

[rtl/core/cidf_ctrl.sv]
// ----------------------------------------------------------------------------
// cidf_ctrl
// Sequencer: takes one request word, walks the slots for a frame or runs
// an add/remove, and paces result words against the output register.
// ----------------------------------------------------------------------------
module cidf_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [cidf_pkg::CMD_W-1:0]    req_cmd,
   output logic                          req_ready,
   input  cidf_pkg::cidf_stat_type       stat_i,
   output cidf_pkg::cidf_cmd_type        cmd_o
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;
   localparam logic [1:0] S_STAT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd_o    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_o.capture = 1'b1;
               unique case (req_cmd) inside
                  cidf_pkg::CMD_FRAME: begin
                     cmd_o.scan_clear = 1'b1;
                     state_in         = S_SCAN;
                  end
                  cidf_pkg::CMD_ADD, cidf_pkg::CMD_REMOVE: begin
                     state_in = S_STAT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // hold while a new hit would displace a pending word that cannot leave
            if (!(stat_i.hit && stat_i.pend_valid && !stat_i.out_free)) begin
               if (stat_i.hit) begin
                  cmd_o.take_hit  = 1'b1;
                  cmd_o.emit_pend = stat_i.pend_valid;
               end
               if ((stat_i.hit && stat_i.cnt_full) || stat_i.last_idx) begin
                  state_in = S_FLUSH;
               end else begin
                  cmd_o.scan_adv = 1'b1;
               end
            end
         end
         S_FLUSH: begin
            if (!stat_i.pend_valid) begin
               state_in = S_IDLE;
            end else if (stat_i.out_free) begin
               cmd_o.emit_pend = 1'b1;
               cmd_o.emit_last = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_STAT: begin
            if (stat_i.out_free) begin
               cmd_o.exec_stat = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/cidf_dp.sv]
// ----------------------------------------------------------------------------
// cidf_dp
// Datapath: request register, filter store, slot scan with one pending
// result, and the output register.
// ----------------------------------------------------------------------------
module cidf_dp #(
   parameter int NUM_SLOTS = cidf_pkg::NUM_SLOTS_DEF,
   parameter int ID_BITS   = cidf_pkg::ID_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [cidf_pkg::CHAN_W-1:0]    csr_wr_data,
   input  logic [cidf_pkg::CMD_W-1:0]     req_cmd,
   input  logic [cidf_pkg::SLOT_W-1:0]    req_slot,
   input  logic [cidf_pkg::KIND_W-1:0]    req_filter_kind,
   input  logic [cidf_pkg::VALUE_W-1:0]   req_mask_value,
   input  logic [cidf_pkg::LEN_W-1:0]     req_mask_length,
   input  logic [cidf_pkg::VALUE_W-1:0]   req_pattern_value,
   input  logic [cidf_pkg::LEN_W-1:0]     req_pattern_length,
   input  logic [cidf_pkg::VALUE_W-1:0]   req_frame_id,
   input  cidf_pkg::cidf_cmd_type         cmd_i,
   output cidf_pkg::cidf_stat_type        stat_o,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_result_kind,
   output logic [cidf_pkg::STATUS_W-1:0]  rsp_status,
   output logic [cidf_pkg::MSLOT_W-1:0]   rsp_matched_slot,
   output logic [cidf_pkg::VALUE_W-1:0]   rsp_forwarded_id,
   output logic [cidf_pkg::CHAN_W-1:0]    rsp_channel,
   output logic                           rsp_last
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = cidf_pkg::CNT_W;
   localparam logic [cidf_pkg::SLOT_W+1:0] SLOTS_C = (cidf_pkg::SLOT_W+2)'(NUM_SLOTS);

   // keep the low bytes given by the length; four or more keeps all
   function automatic logic [cidf_pkg::VALUE_W-1:0] keep_bytes(
      input logic [cidf_pkg::VALUE_W-1:0] v,
      input logic [cidf_pkg::LEN_W-1:0]   len
   );
      logic [cidf_pkg::VALUE_W-1:0] m;
      case (len)
         4'd0:    m = 32'h0000_0000;
         4'd1:    m = 32'h0000_00FF;
         4'd2:    m = 32'h0000_FFFF;
         4'd3:    m = 32'h00FF_FFFF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return v & m;
   endfunction

   // configuration
   logic [cidf_pkg::CHAN_W-1:0]   chan_ff;

   // request word
   logic [cidf_pkg::CMD_W-1:0]    cmd_ff;
   logic [cidf_pkg::SLOT_W-1:0]   slot_ff;
   logic [cidf_pkg::KIND_W-1:0]   kind_ff;
   logic [cidf_pkg::VALUE_W-1:0]  mval_ff;
   logic [cidf_pkg::LEN_W-1:0]    mlen_ff;
   logic [cidf_pkg::VALUE_W-1:0]  pval_ff;
   logic [cidf_pkg::LEN_W-1:0]    plen_ff;
   logic [ID_BITS-1:0]            id_ff;

   // filter store
   logic [NUM_SLOTS-1:0]          used_ff;
   logic [NUM_SLOTS-1:0]          blocks_ff;
   logic [ID_BITS-1:0]            mask_ff    [NUM_SLOTS];
   logic [ID_BITS-1:0]            pattern_ff [NUM_SLOTS];

   // scan
   logic [IDX_W-1:0]              idx_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic [IDX_W-1:0]              pend_ff;
   logic                          pend_valid_ff;

   // output register
   logic                          out_valid_ff;
   logic                          out_kind_ff;
   logic [cidf_pkg::STATUS_W-1:0] out_status_ff;
   logic [cidf_pkg::MSLOT_W-1:0]  out_slot_ff;
   logic [cidf_pkg::VALUE_W-1:0]  out_id_ff;
   logic                          out_last_ff;

   logic                          in_range;
   logic [IDX_W-1:0]              slot_addr;
   logic                          eq;
   logic                          hit;
   logic [cidf_pkg::STATUS_W-1:0] st;
   logic                          do_add;
   logic                          do_remove;
   logic                          out_free;

   assign in_range  = {2'b00, slot_ff} < SLOTS_C;
   assign slot_addr = IDX_W'(slot_ff);
   assign eq        = (id_ff & mask_ff[idx_ff]) == pattern_ff[idx_ff];
   assign hit       = used_ff[idx_ff] && (blocks_ff[idx_ff] ? !eq : eq);
   assign out_free  = !out_valid_ff || rsp_ready;

   // add/remove decision, in priority order
   always_comb begin
      st        = cidf_pkg::ST_OK;
      do_add    = 1'b0;
      do_remove = 1'b0;
      if (cmd_ff == cidf_pkg::CMD_ADD) begin
         if (kind_ff != cidf_pkg::KIND_PASS && kind_ff != cidf_pkg::KIND_BLOCK) begin
            st = cidf_pkg::ST_WRONG_TYPE;
         end else if (mlen_ff > cidf_pkg::LEN_W'(cidf_pkg::MAX_LEN)) begin
            st = cidf_pkg::ST_MASK_LONG;
         end else if (plen_ff > cidf_pkg::LEN_W'(cidf_pkg::MAX_LEN)) begin
            st = cidf_pkg::ST_PAT_LONG;
         end else if (!in_range) begin
            st = cidf_pkg::ST_LIMIT;
         end else if (used_ff[slot_addr]) begin
            st = cidf_pkg::ST_IN_USE;
         end else begin
            do_add = 1'b1;
         end
      end else begin
         if (in_range && used_ff[slot_addr]) begin
            do_remove = 1'b1;
         end else begin
            st = cidf_pkg::ST_NO_FILTER;
         end
      end
   end

   assign stat_o.out_free   = out_free;
   assign stat_o.hit        = hit;
   assign stat_o.last_idx   = (idx_ff == IDX_W'(NUM_SLOTS - 1));
   assign stat_o.cnt_full   = (cnt_ff == CNT_W'(cidf_pkg::MAX_RESULTS - 1));
   assign stat_o.pend_valid = pend_valid_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff       <= '0;
         used_ff       <= '0;
         blocks_ff     <= '0;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            chan_ff <= csr_wr_data;
         end
         if (cmd_i.exec_stat && do_add) begin
            used_ff[slot_addr]   <= 1'b1;
            blocks_ff[slot_addr] <= (kind_ff == cidf_pkg::KIND_BLOCK);
         end
         if (cmd_i.exec_stat && do_remove) begin
            used_ff[slot_addr]   <= 1'b0;
            blocks_ff[slot_addr] <= 1'b0;
         end
         if (cmd_i.scan_clear) begin
            idx_ff        <= '0;
            cnt_ff        <= '0;
            pend_valid_ff <= 1'b0;
         end else begin
            if (cmd_i.scan_adv) begin
               idx_ff <= idx_ff + 1'b1;
            end
            if (cmd_i.take_hit) begin
               cnt_ff        <= cnt_ff + 1'b1;
               pend_valid_ff <= 1'b1;
            end else if (cmd_i.emit_pend) begin
               pend_valid_ff <= 1'b0;
            end
         end
         if (cmd_i.emit_pend || cmd_i.exec_stat) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd_i.capture) begin
         cmd_ff  <= req_cmd;
         slot_ff <= req_slot;
         kind_ff <= req_filter_kind;
         mval_ff <= req_mask_value;
         mlen_ff <= req_mask_length;
         pval_ff <= req_pattern_value;
         plen_ff <= req_pattern_length;
         id_ff   <= req_frame_id[ID_BITS-1:0];
      end
      if (cmd_i.exec_stat && do_add) begin
         mask_ff[slot_addr]    <= ID_BITS'(keep_bytes(mval_ff, mlen_ff));
         pattern_ff[slot_addr] <= ID_BITS'(keep_bytes(pval_ff, plen_ff));
      end
      if (cmd_i.take_hit) begin
         pend_ff <= idx_ff;
      end
      if (cmd_i.emit_pend) begin
         out_kind_ff   <= cidf_pkg::RES_FORWARD;
         out_status_ff <= cidf_pkg::ST_OK;
         out_slot_ff   <= cidf_pkg::MSLOT_W'(pend_ff);
         out_id_ff     <= cidf_pkg::VALUE_W'(id_ff);
         out_last_ff   <= cmd_i.emit_last;
      end else if (cmd_i.exec_stat) begin
         out_kind_ff   <= cidf_pkg::RES_STATUS;
         out_status_ff <= st;
         out_slot_ff   <= '0;
         out_id_ff     <= '0;
         out_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_kind_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_matched_slot = out_slot_ff;
   assign rsp_forwarded_id = out_id_ff;
   assign rsp_channel      = chan_ff;
   assign rsp_last         = out_last_ff;

endmodule

[rtl/core/can_id_pass_block_filter_bank_unit.sv]
// ----------------------------------------------------------------------------
// can_id_pass_block_filter_bank_unit
// Bank of mask/pattern filters on CAN identifiers with add/remove commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one command word: frame arrives, add filter or remove
//   filter. rsp_ch returns result words; last marks the final word of a
//   command. Add and remove answer with one status word. A frame gives one
//   forwarded word per slot that lets it through, in slot order, or none.
//   csr_wr_en/csr_wr_data load the channel number stamped on every word;
//   write it only while the unit is idle.
//   Timing, unstalled: commands are taken only while idle. Add/remove: the
//   status word is loaded from S_STAT as the unit returns to idle.
//   Frame: one slot per cycle, one hit held back for last; the last word,
//   if any, is loaded from S_FLUSH as the unit returns to idle.
//   A stalled rsp_ch holds the output register; the scan stops on the next
//   hit until the held word is taken, and no word is lost.
//   Reset (synchronous, active high) clears all slots, the channel number
//   and the output register.
// ----------------------------------------------------------------------------
module can_id_pass_block_filter_bank_unit #(
   parameter int NUM_SLOTS = cidf_pkg::NUM_SLOTS_DEF,
   parameter int ID_BITS   = cidf_pkg::ID_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [cidf_pkg::CHAN_W-1:0]  csr_wr_data,
   cidf_req_if.sink                     req_ch,
   cidf_rsp_if.source                   rsp_ch
);

   cidf_pkg::cidf_cmd_type  cmd;
   cidf_pkg::cidf_stat_type stat;

   cidf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .stat_i    (stat),
      .cmd_o     (cmd)
   );

   cidf_dp #(
      .NUM_SLOTS (NUM_SLOTS),
      .ID_BITS   (ID_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_cmd            (req_ch.cmd),
      .req_slot           (req_ch.slot),
      .req_filter_kind    (req_ch.filter_kind),
      .req_mask_value     (req_ch.mask_value),
      .req_mask_length    (req_ch.mask_length),
      .req_pattern_value  (req_ch.pattern_value),
      .req_pattern_length (req_ch.pattern_length),
      .req_frame_id       (req_ch.frame_id),
      .cmd_i              (cmd),
      .stat_o             (stat),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_result_kind    (rsp_ch.result_kind),
      .rsp_status         (rsp_ch.status),
      .rsp_matched_slot   (rsp_ch.matched_slot),
      .rsp_forwarded_id   (rsp_ch.forwarded_id),
      .rsp_channel        (rsp_ch.channel),
      .rsp_last           (rsp_ch.last)
   );

endmodule
